>>> src/rtsu_pkg.sv
// shared types and constants for the reference table store
package rtsu_pkg;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 104;
    localparam int ENTRY_W   = 34;
    localparam int M_RKIND_LSB = 65;

    localparam logic [2:0] KIND_ALLOC = 3'd0;
    localparam logic [2:0] KIND_TYPE  = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_SIZE  = 3'd4;
    localparam logic [2:0] KIND_GROW  = 3'd5;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_OOB     = 3'd1;
    localparam logic [2:0] STATUS_GROW    = 3'd2;
    localparam logic [2:0] STATUS_FULL    = 3'd3;
    localparam logic [2:0] STATUS_UNALLOC = 3'd4;
    localparam logic [2:0] STATUS_BIG     = 3'd5;

    localparam logic [1:0] RKIND_FUNC   = 2'd0;
    localparam logic [1:0] RKIND_EXTERN = 2'd1;
    localparam logic [1:0] RKIND_NONE   = 2'd2;
    localparam logic [1:0] RKIND_BAD    = 2'd3;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fill;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_fill;
        logic fill_last;
    } dp_status_t;

endpackage

>>> src/rtsu_ctrl.sv
// controller state machine sequencing accept, execute, fill and result load
module rtsu_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  rtsu_pkg::dp_status_t   sts,
    output rtsu_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   load_ok;

    assign load_ok  = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    assign cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign cmd.fill   = (state_reg == ST_FILL);
    assign cmd.load   = (state_reg == ST_FINISH) && load_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= sts.need_fill ? ST_FILL : ST_FINISH;
                end
                ST_FILL: begin
                    if (sts.fill_last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (load_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/rtsu_datapath.sv
// datapath: operation registers, table descriptors, entry memory and result register
module rtsu_datapath #(
    parameter int NUM_TABLES  = 4,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtsu_pkg::ctrl_cmd_t   cmd,
    output rtsu_pkg::dp_status_t  sts,
    input  logic [2:0]            kind,
    input  logic [1:0]            table_id,
    input  logic [31:0]           entry_index,
    input  logic [31:0]           count,
    input  logic [31:0]           limit_max,
    input  logic                  table_reftype,
    input  logic                  ref_kind,
    input  logic [31:0]           ref_addr,
    input  logic                  ref_null,
    output logic [2:0]            status,
    output logic [31:0]           value,
    output logic [31:0]           max_out,
    output logic                  reftype_out,
    output logic [1:0]            read_kind,
    output logic [31:0]           read_addr,
    output logic                  read_null
);

    localparam int ENTRIES = NUM_TABLES * TABLE_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TID_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SZ_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IU_W    = $clog2(NUM_TABLES + 1);
    localparam int CMP_W   = (IU_W > 2) ? IU_W : 2;
    localparam int EW      = rtsu_pkg::ENTRY_W;

    // latched operation
    logic [2:0]  kind_reg;
    logic [1:0]  tid_reg;
    logic [31:0] idx_reg;
    logic [31:0] cnt_reg;
    logic [31:0] lmax_reg;
    logic        ttype_reg;
    logic [EW-1:0] word_reg;

    // table descriptors
    logic [SZ_W-1:0] size_reg  [NUM_TABLES];
    logic [31:0]     limit_reg [NUM_TABLES];
    logic            type_reg  [NUM_TABLES];
    logic [IU_W-1:0] in_use_reg;

    // fill sequencer
    logic [SZ_W-1:0]   fill_ptr_reg;
    logic [SZ_W-1:0]   fill_end_reg;
    logic [ADDR_W-1:0] fill_base_reg;

    // pending result
    logic [2:0]  pend_status_reg;
    logic [31:0] pend_value_reg;
    logic [31:0] pend_max_reg;
    logic        pend_rtype_reg;
    logic [1:0]  pend_rkind_reg;
    logic [31:0] pend_raddr_reg;
    logic        pend_rnull_reg;
    logic        pend_mem_reg;

    // output register
    logic [2:0]  status_reg;
    logic [31:0] value_reg;
    logic [31:0] max_reg;
    logic        rtype_reg;
    logic [1:0]  rkind_reg;
    logic [31:0] raddr_reg;
    logic        rnull_reg;

    logic [EW-1:0] mem [ENTRIES];
    logic [EW-1:0] rd_data_reg;

    logic [TID_W-1:0]  tsel;
    logic [TID_W-1:0]  alloc_t;
    logic [SZ_W-1:0]   cur_size;
    logic [31:0]       cur_limit;
    logic              cur_type;
    logic              unalloc;
    logic              full;
    logic              big;
    logic              oob;
    logic [32:0]       grow_sum;
    logic              grow_bad;
    logic [ADDR_W-1:0] tbl_base;
    logic [ADDR_W-1:0] alloc_base;
    logic [ADDR_W-1:0] acc_addr;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_we;

    logic [2:0]  p_status;
    logic [31:0] p_value;
    logic [31:0] p_max;
    logic        p_rtype;
    logic [1:0]  p_rkind;
    logic [31:0] p_raddr;
    logic        p_rnull;
    logic        do_alloc;
    logic        do_grow;
    logic        do_write;
    logic        do_read;
    logic [SZ_W-1:0]   f_start;
    logic [SZ_W-1:0]   f_end;
    logic [ADDR_W-1:0] f_base;

    assign tsel      = TID_W'(tid_reg);
    assign alloc_t   = TID_W'(in_use_reg);
    assign cur_size  = size_reg[tsel];
    assign cur_limit = limit_reg[tsel];
    assign cur_type  = type_reg[tsel];

    assign unalloc  = CMP_W'(tid_reg) >= CMP_W'(in_use_reg);
    assign full     = in_use_reg >= IU_W'(NUM_TABLES);
    assign big      = cnt_reg > 32'(TABLE_DEPTH);
    assign oob      = idx_reg >= 32'(cur_size);
    assign grow_sum = {1'b0, 32'(cur_size)} + {1'b0, cnt_reg};
    assign grow_bad = (grow_sum > {1'b0, cur_limit}) || (grow_sum > 33'(TABLE_DEPTH));

    assign tbl_base   = ADDR_W'(tsel) * ADDR_W'(TABLE_DEPTH);
    assign alloc_base = ADDR_W'(alloc_t) * ADDR_W'(TABLE_DEPTH);
    assign acc_addr   = tbl_base + ADDR_W'(idx_reg[IDX_W-1:0]);

    always_comb begin
        p_status = rtsu_pkg::STATUS_OK;
        p_value  = '0;
        p_max    = '0;
        p_rtype  = 1'b0;
        p_rkind  = rtsu_pkg::RKIND_FUNC;
        p_raddr  = '0;
        p_rnull  = 1'b0;
        do_alloc = 1'b0;
        do_grow  = 1'b0;
        do_write = 1'b0;
        do_read  = 1'b0;
        f_start  = '0;
        f_end    = SZ_W'(cnt_reg);
        f_base   = alloc_base;
        case (kind_reg)
            rtsu_pkg::KIND_ALLOC: begin
                if (full) begin
                    p_status = rtsu_pkg::STATUS_FULL;
                end else if (big) begin
                    p_status = rtsu_pkg::STATUS_BIG;
                end else begin
                    do_alloc = 1'b1;
                    p_value  = 32'(in_use_reg);
                end
            end
            rtsu_pkg::KIND_TYPE, rtsu_pkg::KIND_READ, rtsu_pkg::KIND_WRITE,
            rtsu_pkg::KIND_SIZE, rtsu_pkg::KIND_GROW: begin
                if (unalloc) begin
                    p_status = rtsu_pkg::STATUS_UNALLOC;
                end else begin
                    case (kind_reg)
                        rtsu_pkg::KIND_TYPE: begin
                            p_value = 32'(cur_size);
                            p_max   = cur_limit;
                            p_rtype = cur_type;
                        end
                        rtsu_pkg::KIND_READ: begin
                            if (oob) begin
                                p_status = rtsu_pkg::STATUS_OOB;
                                p_rkind  = rtsu_pkg::RKIND_NONE;
                                p_raddr  = '1;
                                p_rnull  = 1'b1;
                            end else begin
                                do_read = 1'b1;
                            end
                        end
                        rtsu_pkg::KIND_WRITE: begin
                            if (oob) begin
                                p_status = rtsu_pkg::STATUS_OOB;
                            end else begin
                                do_write = 1'b1;
                            end
                        end
                        rtsu_pkg::KIND_SIZE: begin
                            p_value = 32'(cur_size);
                        end
                        rtsu_pkg::KIND_GROW: begin
                            if (grow_bad) begin
                                p_status = rtsu_pkg::STATUS_GROW;
                                p_value  = '1;
                            end else begin
                                do_grow = 1'b1;
                                p_value = 32'(cur_size);
                                f_start = cur_size;
                                f_end   = SZ_W'(grow_sum);
                                f_base  = tbl_base;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign sts.need_fill = (do_alloc || do_grow) && (cnt_reg != '0);
    assign sts.fill_last = SZ_W'(fill_ptr_reg + 1'b1) == fill_end_reg;

    assign mem_we    = (cmd.exec && do_write) || cmd.fill;
    assign mem_waddr = cmd.fill ? (fill_base_reg + ADDR_W'(fill_ptr_reg)) : acc_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_read) begin
            rd_data_reg <= mem[acc_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (cmd.exec && do_alloc) begin
            in_use_reg <= in_use_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= kind;
            tid_reg   <= table_id;
            idx_reg   <= entry_index;
            cnt_reg   <= count;
            lmax_reg  <= limit_max;
            ttype_reg <= table_reftype;
            word_reg  <= {ref_null, ref_kind, ref_addr};
        end
        if (cmd.exec) begin
            pend_status_reg <= p_status;
            pend_value_reg  <= p_value;
            pend_max_reg    <= p_max;
            pend_rtype_reg  <= p_rtype;
            pend_rkind_reg  <= p_rkind;
            pend_raddr_reg  <= p_raddr;
            pend_rnull_reg  <= p_rnull;
            pend_mem_reg    <= do_read;
            fill_ptr_reg    <= f_start;
            fill_end_reg    <= f_end;
            fill_base_reg   <= f_base;
        end else if (cmd.fill) begin
            fill_ptr_reg <= fill_ptr_reg + 1'b1;
        end
        if (cmd.exec && do_alloc) begin
            size_reg[alloc_t]  <= SZ_W'(cnt_reg);
            limit_reg[alloc_t] <= lmax_reg;
            type_reg[alloc_t]  <= ttype_reg;
        end else if (cmd.exec && do_grow) begin
            size_reg[tsel] <= SZ_W'(grow_sum);
        end
        if (cmd.load) begin
            status_reg <= pend_status_reg;
            value_reg  <= pend_value_reg;
            max_reg    <= pend_max_reg;
            rtype_reg  <= pend_rtype_reg;
            if (pend_mem_reg) begin
                rkind_reg <= {1'b0, rd_data_reg[32]};
                raddr_reg <= rd_data_reg[31:0];
                rnull_reg <= rd_data_reg[33];
            end else begin
                rkind_reg <= pend_rkind_reg;
                raddr_reg <= pend_raddr_reg;
                rnull_reg <= pend_rnull_reg;
            end
        end
    end

    assign status      = status_reg;
    assign value       = value_reg;
    assign max_out     = max_reg;
    assign reftype_out = rtype_reg;
    assign read_kind   = rkind_reg;
    assign read_addr   = raddr_reg;
    assign read_null   = rnull_reg;

endmodule

>>> src/reference_table_store_unit.sv
// top level of the reference table store
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_      | in  | table_id, entry_index, count, limit_max,          | kind
//          |     | table_reftype, ref_kind, ref_addr, ref_null       |
//  m_      | out | value, max_out, reftype_out, read_kind,           | status
//          |     | read_addr, read_null                              |
//
//  type, size, read, write and refused operations pass through accept, execute and
//  result load; alloc and grow add a fill step for each new entry,
//  bound by the single write port of the entry memory
//  reset clears the table count and handshake state; the entry memory is not cleared
//  a new transaction is accepted while the previous result waits on m_tready;
//  a result stalled at the output holds the next one in its result load state
module reference_table_store_unit #(
    parameter int NUM_TABLES  = 4,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // table_id, entry_index, count, limit_max, table_reftype, ref_kind, ref_addr, ref_null
    input  logic [rtsu_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // value, max_out, reftype_out, read_kind, read_addr, read_null
    output logic [rtsu_pkg::M_TDATA_W-1:0]     m_tdata,
    // status
    output logic [2:0]                         m_tuser
);

    rtsu_pkg::ctrl_cmd_t  cmd;
    rtsu_pkg::dp_status_t sts;

    logic [31:0] value;
    logic [31:0] max_out;
    logic        reftype_out;
    logic [1:0]  read_kind;
    logic [31:0] read_addr;
    logic        read_null;

    rtsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtsu_datapath #(
        .NUM_TABLES  (NUM_TABLES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (s_tuser),
        .table_id      (s_tdata[1:0]),
        .entry_index   (s_tdata[33:2]),
        .count         (s_tdata[65:34]),
        .limit_max     (s_tdata[97:66]),
        .table_reftype (s_tdata[98]),
        .ref_kind      (s_tdata[99]),
        .ref_addr      (s_tdata[131:100]),
        .ref_null      (s_tdata[132]),
        .status        (m_tuser),
        .value         (value),
        .max_out       (max_out),
        .reftype_out   (reftype_out),
        .read_kind     (read_kind),
        .read_addr     (read_addr),
        .read_null     (read_null)
    );

    assign m_tdata = {4'b0000, read_null, read_addr, read_kind, reftype_out, max_out, value};

endmodule

>>> src/rtsu_checker.sv
// port-level checks for the reference table store and their binding
module rtsu_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [rtsu_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [2:0]                         m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input ready drops after each accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= rtsu_pkg::STATUS_BIG)
        else $error("status code out of range");

    a_read_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[rtsu_pkg::M_RKIND_LSB +: 2] != rtsu_pkg::RKIND_BAD)
        else $error("read kind code out of range");

endmodule

bind reference_table_store_unit rtsu_checker u_rtsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/reference_table_store_unit_test.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the reference table store with its own table model
module reference_table_store_unit_test;

    localparam int NUM_TABLES   = 4;
    localparam int TABLE_DEPTH  = 1024;
    localparam int RANDOM_OPS   = 1080;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0]  KIND_RSVD_6 = 3'd6;
    localparam logic [2:0]  KIND_RSVD_7 = 3'd7;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        ref_null;
        logic [31:0] ref_addr;
        logic        ref_kind;
        logic        table_reftype;
        logic [31:0] limit_max;
        logic [31:0] count;
        logic [31:0] entry_index;
        logic [1:0]  table_id;
    } op_fields_t;

    typedef struct packed {
        logic [2:0] kind;
        op_fields_t f;
    } table_op_t;

    typedef struct packed {
        logic        read_null;
        logic [31:0] read_addr;
        logic [1:0]  read_kind;
        logic        reftype_out;
        logic [31:0] max_out;
        logic [31:0] value;
    } table_res_t;

    typedef struct packed {
        logic [2:0] status;
        table_res_t r;
    } table_reply_t;

    localparam int OP_BITS  = $bits(op_fields_t);
    localparam int RES_BITS = $bits(table_res_t);

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rtsu_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [2:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rtsu_pkg::M_TDATA_W-1:0] m_tdata;
    logic [2:0]                     m_tuser;

    table_op_t    op_queue[$];
    table_reply_t expected_replies[$];

    logic [rtsu_pkg::ENTRY_W-1:0] slot_mem [NUM_TABLES*TABLE_DEPTH];
    logic [31:0]        tbl_size [NUM_TABLES] = '{default: '0};
    logic [31:0]        tbl_max  [NUM_TABLES] = '{default: '0};
    logic               tbl_type [NUM_TABLES] = '{default: 1'b0};
    int                 tables_used = 0;

    int src_idle_pct   = 26;
    int sink_idle_pct  = 60;
    int stall_requests = 0;
    int stall_served   = 0;
    int hold_left      = 0;
    int fail_count     = 0;

    reference_table_store_unit #(
        .NUM_TABLES (NUM_TABLES),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic table_reply_t apply_table_op(table_op_t op);
        table_reply_t                 rep;
        logic [rtsu_pkg::ENTRY_W-1:0] word;
        logic [rtsu_pkg::ENTRY_W-1:0] slot;
        logic [32:0]                  grown_size;
        int                           t;
        int                           i;
        rep = '0;
        word = {op.f.ref_null, op.f.ref_kind, op.f.ref_addr};
        t = op.f.table_id;
        if (op.kind == KIND_RSVD_6 || op.kind == KIND_RSVD_7) begin
            return rep;
        end
        if (op.kind == rtsu_pkg::KIND_ALLOC) begin
            if (tables_used >= NUM_TABLES) begin
                rep.status = rtsu_pkg::STATUS_FULL;
            end else if (op.f.count > TABLE_DEPTH) begin
                rep.status = rtsu_pkg::STATUS_BIG;
            end else begin
                t = tables_used;
                tbl_type[t] = op.f.table_reftype;
                tbl_max[t] = op.f.limit_max;
                tbl_size[t] = op.f.count;
                for (i = 0; i < int'(op.f.count); i++) begin
                    slot_mem[t*TABLE_DEPTH + i] = word;
                end
                tables_used = t + 1;
                rep.status = rtsu_pkg::STATUS_OK;
                rep.r.value = t;
            end
            return rep;
        end
        if (t >= tables_used) begin
            rep.status = rtsu_pkg::STATUS_UNALLOC;
            return rep;
        end
        case (op.kind)
            rtsu_pkg::KIND_TYPE: begin
                rep.r.value = tbl_size[t];
                rep.r.max_out = tbl_max[t];
                rep.r.reftype_out = tbl_type[t];
            end
            rtsu_pkg::KIND_READ: begin
                if (op.f.entry_index >= tbl_size[t]) begin
                    rep.status = rtsu_pkg::STATUS_OOB;
                    rep.r.read_kind = rtsu_pkg::RKIND_NONE;
                    rep.r.read_addr = ALL_ONES;
                    rep.r.read_null = 1'b1;
                end else begin
                    slot = slot_mem[t*TABLE_DEPTH + int'(op.f.entry_index)];
                    rep.r.read_kind = {1'b0, slot[32]};
                    rep.r.read_addr = slot[31:0];
                    rep.r.read_null = slot[33];
                end
            end
            rtsu_pkg::KIND_WRITE: begin
                if (op.f.entry_index >= tbl_size[t]) begin
                    rep.status = rtsu_pkg::STATUS_OOB;
                end else begin
                    slot_mem[t*TABLE_DEPTH + int'(op.f.entry_index)] = word;
                end
            end
            rtsu_pkg::KIND_SIZE: begin
                rep.r.value = tbl_size[t];
            end
            rtsu_pkg::KIND_GROW: begin
                grown_size = {1'b0, tbl_size[t]} + {1'b0, op.f.count};
                if (grown_size > {1'b0, tbl_max[t]} || grown_size >= {1'b0, ALL_ONES}
                        || grown_size > TABLE_DEPTH) begin
                    rep.status = rtsu_pkg::STATUS_GROW;
                    rep.r.value = ALL_ONES;
                end else begin
                    for (i = int'(tbl_size[t]); i < int'(grown_size); i++) begin
                        slot_mem[t*TABLE_DEPTH + i] = word;
                    end
                    rep.r.value = tbl_size[t];
                    tbl_size[t] = grown_size[31:0];
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic table_op_t random_fields();
        table_op_t    op;
        logic [159:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        op.kind = 3'($urandom_range(0, 7));
        op.f = bits[OP_BITS-1:0];
        return op;
    endfunction

    task automatic queue_op(logic [2:0] kind, logic [1:0] tid, logic [31:0] idx,
                            logic [31:0] cnt, logic [31:0] lmax, logic ttype);
        table_op_t op;
        op = random_fields();
        op.kind = kind;
        op.f.table_id = tid;
        op.f.entry_index = idx;
        op.f.count = cnt;
        op.f.limit_max = lmax;
        op.f.table_reftype = ttype;
        op_queue.push_back(op);
    endtask

    task automatic queue_random_ops(int n);
        table_op_t op;
        int        pick;
        repeat (n) begin
            op = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 4) op.kind = rtsu_pkg::KIND_ALLOC;
            else if (pick < 6) op.kind = pick[0] ? KIND_RSVD_7 : KIND_RSVD_6;
            else if (pick < 20) op.kind = rtsu_pkg::KIND_TYPE;
            else if (pick < 45) op.kind = rtsu_pkg::KIND_READ;
            else if (pick < 70) op.kind = rtsu_pkg::KIND_WRITE;
            else if (pick < 80) op.kind = rtsu_pkg::KIND_SIZE;
            else op.kind = rtsu_pkg::KIND_GROW;
            case ($urandom_range(0, 9))
                0, 1: ;
                2, 3, 4: op.f.entry_index = $urandom_range(0, TABLE_DEPTH + 76);
                default: op.f.entry_index = $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2: ;
                3, 4, 5, 6: op.f.count = $urandom_range(0, TABLE_DEPTH + 4);
                default: op.f.count = $urandom_range(0, 6);
            endcase
            case ($urandom_range(0, 3))
                0: ;
                1: op.f.limit_max = ALL_ONES;
                default: op.f.limit_max = $urandom_range(0, 64);
            endcase
            op_queue.push_back(op);
        end
    endtask

    task automatic wait_all_replies();
        do @(negedge aclk);
        while (op_queue.size() != 0 || s_tvalid || expected_replies.size() != 0);
    endtask

    always @(posedge aclk) begin : drive_ops
        table_op_t next_op;
        logic      offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(
                    apply_table_op(table_op_t'({s_tuser, s_tdata[OP_BITS-1:0]})));
                offer = 1'b0;
            end
            if (!offer && op_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_op = op_queue.pop_front();
                s_tdata <= {{(rtsu_pkg::S_TDATA_W-OP_BITS){1'b0}}, next_op.f};
                s_tuser <= next_op.kind;
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    always @(posedge aclk) begin : collect_replies
        table_reply_t want;
        table_res_t   got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_BITS-1:0];
                if (expected_replies.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d", m_tuser);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("value", want.r.value, got.value);
                    check_field("max_out", want.r.max_out, got.max_out);
                    check_field("reftype_out", want.r.reftype_out, got.reftype_out);
                    check_field("read_kind", want.r.read_kind, got.read_kind);
                    check_field("read_addr", want.r.read_addr, got.read_addr);
                    check_field("read_null", want.r.read_null, got.read_null);
                end
            end
            if (stall_served != stall_requests) begin
                stall_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin : run_test
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        queue_op(rtsu_pkg::KIND_SIZE, 2'd0, $urandom, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd3, 32'd0, $urandom, $urandom, 1'b1);
        queue_op(rtsu_pkg::KIND_WRITE, 2'd2, 32'd0, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_GROW, 2'd1, $urandom, 32'd1, $urandom, 1'b1);
        queue_op(rtsu_pkg::KIND_TYPE, 2'd0, $urandom, $urandom, $urandom, 1'b0);
        queue_op(KIND_RSVD_6, 2'd1, $urandom, $urandom, $urandom, 1'b1);
        queue_op(KIND_RSVD_7, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        queue_op(rtsu_pkg::KIND_ALLOC, 2'd0, $urandom, TABLE_DEPTH + 1, ALL_ONES, 1'b0);
        queue_op(rtsu_pkg::KIND_ALLOC, 2'd3, $urandom, ALL_ONES, ALL_ONES, 1'b1);
        queue_op(rtsu_pkg::KIND_ALLOC, 2'd2, $urandom, 32'd0, ALL_ONES, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd0, 32'd0, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_GROW, 2'd0, $urandom, ALL_ONES, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_GROW, 2'd0, $urandom, 32'd0, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_GROW, 2'd0, $urandom, 32'd16, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_ALLOC, 2'd1, $urandom, TABLE_DEPTH, 32'd0, 1'b1);
        queue_op(rtsu_pkg::KIND_GROW, 2'd1, $urandom, 32'd0, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd1, TABLE_DEPTH - 1, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd1, TABLE_DEPTH, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_WRITE, 2'd1, ALL_ONES, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_WRITE, 2'd1, TABLE_DEPTH - 1, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd1, TABLE_DEPTH - 1, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_TYPE, 2'd1, $urandom, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_SIZE, 2'd0, $urandom, $urandom, $urandom, 1'b0);
        queue_op(rtsu_pkg::KIND_READ, 2'd0, ALL_ONES, $urandom, $urandom, 1'b0);

        queue_random_ops(RANDOM_OPS / 3);
        wait_all_replies();

        src_idle_pct = 60;
        sink_idle_pct = 26;
        queue_random_ops(RANDOM_OPS / 3);
        wait_all_replies();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        queue_random_ops(RANDOM_OPS / 6);
        stall_requests++;
        queue_random_ops(RANDOM_OPS / 6);
        wait_all_replies();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
src/rtsu_pkg.sv
src/rtsu_ctrl.sv
src/rtsu_datapath.sv
src/reference_table_store_unit.sv
src/rtsu_checker.sv
tb/reference_table_store_unit_test.sv
